/* rtl/d8sdd_pkg.sv */
// ----------------------------------------------------------------------------
// D8 flow direction package
// Shared types, chain codes and slope constants for the D8 flow direction block.
// ----------------------------------------------------------------------------
`default_nettype none

package d8sdd_pkg;

  // Width of the elevation fields on the ports.
  localparam int unsigned ELEV_IN_W = 16;

  // Default internal elevation width.
  localparam int unsigned ELEV_BITS_DEF = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // sqrt(2) in Q16, rounded to nearest; diagonal drops carry a weight of one.
  localparam int unsigned Q_FRAC = 16;
  localparam logic [16:0] SQRT2_Q16 = 17'd92682;

  // Keypad chain codes: 7 8 9 north row, 4 6 same row, 1 2 3 south row.
  localparam logic [3:0] DIR_NONE   = 4'd0;
  localparam logic [3:0] DIR_SW     = 4'd1;
  localparam logic [3:0] DIR_S      = 4'd2;
  localparam logic [3:0] DIR_SE     = 4'd3;
  localparam logic [3:0] DIR_W      = 4'd4;
  localparam logic [3:0] DIR_CENTRE = 4'd5;
  localparam logic [3:0] DIR_E      = 4'd6;
  localparam logic [3:0] DIR_NW     = 4'd7;
  localparam logic [3:0] DIR_N      = 4'd8;
  localparam logic [3:0] DIR_NE     = 4'd9;

  typedef struct packed {
    logic signed [ELEV_IN_W-1:0] elev_above;
    logic signed [ELEV_IN_W-1:0] elev_here;
    logic signed [ELEV_IN_W-1:0] elev_below;
    logic                        above_valid;
    logic                        below_valid;
    logic                        row_end;
  } d8sdd_in_t;

  typedef struct packed {
    logic [3:0] direction;
    logic       last_of_run;
  } d8sdd_out_t;

  // Column slot status of the front.
  typedef struct packed {
    logic have_left;
    logic have_center;
  } d8sdd_front_st_t;

  // A job holds three slices of (3 samples + 3 flag bits) and two window marks.
  function automatic int unsigned job_w(int unsigned eb);
    return 3 * (3 * eb + 3) + 2;
  endfunction

endpackage

`default_nettype wire

/* rtl/d8sdd_front.sv */
// ----------------------------------------------------------------------------
// D8 flow direction front
// Holds the left and center column slices and turns each accepted slice that
// completes a window into a job that names the windows to be evaluated.
// ----------------------------------------------------------------------------
`default_nettype none

module d8sdd_front #(
  parameter int unsigned ElevBits = d8sdd_pkg::ELEV_BITS_DEF,
  localparam int unsigned JobW = d8sdd_pkg::job_w(ElevBits)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire d8sdd_pkg::d8sdd_in_t        in_data_i,
  output logic                             push_valid_o,
  input  wire logic                        push_ready_i,
  output logic [JobW-1:0]                  push_job_o,
  output d8sdd_pkg::d8sdd_front_st_t       status_o
);
  import d8sdd_pkg::*;

  typedef struct packed {
    logic                         present;
    logic                         below_ok;
    logic                         above_ok;
    logic [2:0][ElevBits-1:0]     v;
  } slice_t;

  typedef struct packed {
    logic   has_a;
    logic   has_b;
    slice_t l;
    slice_t c;
    slice_t n;
  } job_t;

  slice_t left_q, left_d;
  slice_t center_q, center_d;
  slice_t new_slice;
  job_t   job;
  logic   accept;

  // The port field is read as an ElevBits-bit two's complement value.
  function automatic logic [ElevBits-1:0] to_elev(logic [ELEV_IN_W-1:0] x);
    logic [ElevBits+ELEV_IN_W-1:0] w;
    w = {{ElevBits{x[ELEV_IN_W-1]}}, x};
    return w[ElevBits-1:0];
  endfunction

  always_comb begin
    new_slice.present  = 1'b1;
    new_slice.above_ok = in_data_i.above_valid;
    new_slice.below_ok = in_data_i.below_valid;
    new_slice.v[0]     = to_elev(in_data_i.elev_above);
    new_slice.v[1]     = to_elev(in_data_i.elev_here);
    new_slice.v[2]     = to_elev(in_data_i.elev_below);
  end

  always_comb begin
    job.has_a = center_q.present;
    job.has_b = in_data_i.row_end;
    job.l     = left_q;
    job.c     = center_q;
    job.n     = new_slice;
  end

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  // Only slices that complete at least one window produce a job.
  assign push_valid_o = in_valid_i && (center_q.present || in_data_i.row_end);
  assign push_job_o   = job;

  always_comb begin
    left_d   = left_q;
    center_d = center_q;
    if (accept) begin
      if (in_data_i.row_end) begin
        left_d.present   = 1'b0;
        center_d.present = 1'b0;
      end else begin
        left_d   = center_q;
        center_d = new_slice;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      center_q <= '0;
    end else begin
      left_q   <= left_d;
      center_q <= center_d;
    end
  end

  assign status_o.have_left   = left_q.present;
  assign status_o.have_center = center_q.present;

endmodule

`default_nettype wire

/* rtl/d8sdd_queue.sv */
// ----------------------------------------------------------------------------
// D8 flow direction job queue
// Small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module d8sdd_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);
  import d8sdd_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [Width-1:0] store_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/d8sdd_back.sv */
// ----------------------------------------------------------------------------
// D8 flow direction back
// Issues one 3x3 window per unstalled cycle from queued jobs; finds the steepest
// descent in four stages: drops, group maxima, slope weighting, final choice.
// ----------------------------------------------------------------------------
`default_nettype none

module d8sdd_back #(
  parameter int unsigned ElevBits = d8sdd_pkg::ELEV_BITS_DEF,
  localparam int unsigned JobW = d8sdd_pkg::job_w(ElevBits)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  output logic                        job_ready_o,
  input  wire logic [JobW-1:0]        job_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output d8sdd_pkg::d8sdd_out_t       out_data_o
);
  import d8sdd_pkg::*;

  localparam int unsigned WeightW = ElevBits + 17;

  typedef struct packed {
    logic                         present;
    logic                         below_ok;
    logic                         above_ok;
    logic [2:0][ElevBits-1:0]     v;
  } slice_t;

  typedef struct packed {
    logic   has_a;
    logic   has_b;
    slice_t l;
    slice_t c;
    slice_t n;
  } job_t;

  job_t   head;
  slice_t win_l, win_c, win_r;
  logic   adv, issue, use_a, win_last, pop;
  logic   phase_q, phase_d;

  // Stage 1: drops of the four cardinal (codes 2 4 6 8) and four diagonal
  // (codes 1 3 7 9) neighbours, zero where a neighbour is missing or not lower.
  logic                     s1_valid_q;
  logic                     s1_last_q;
  logic [3:0][ElevBits-1:0] s1_card_q, s1_card_d;
  logic [3:0][ElevBits-1:0] s1_diag_q, s1_diag_d;

  // Stage 2: largest drop of each group, first code on equal drops.
  logic                s2_valid_q;
  logic                s2_last_q;
  logic [ElevBits-1:0] s2_dc_q, s2_dc_d;
  logic [ElevBits-1:0] s2_dd_q, s2_dd_d;
  logic [3:0]          s2_cc_q, s2_cc_d;
  logic [3:0]          s2_cd_q, s2_cd_d;

  // Stage 3: slope weights.
  logic               s3_valid_q;
  logic               s3_last_q;
  logic [WeightW-1:0] s3_wc_q;
  logic [WeightW-1:0] s3_wd_q;
  logic [3:0]         s3_cc_q;
  logic [3:0]         s3_cd_q;

  logic       out_valid_q;
  d8sdd_out_t out_q, out_d;

  function automatic logic [ElevBits-1:0] drop_of(logic ok, logic [ElevBits-1:0] nb,
                                                  logic [ElevBits-1:0] ctr);
    logic [ElevBits:0] diff;
    diff = {ctr[ElevBits-1], ctr} - {nb[ElevBits-1], nb};
    if (ok && ($signed(nb) < $signed(ctr))) begin
      return diff[ElevBits-1:0];
    end
    return '0;
  endfunction

  assign head = job_i;
  assign adv  = !out_valid_q || out_ready_i;
  assign issue = adv && job_valid_i;

  // A job with a held center is evaluated for that center first; a row end
  // adds a second window for the new slice, which has no right column.
  assign use_a    = head.has_a && !phase_q;
  assign win_last = use_a ? !head.has_b : 1'b1;
  assign pop      = issue && win_last;
  assign job_ready_o = pop;

  always_comb begin
    if (use_a) begin
      win_l = head.l;
      win_c = head.c;
      win_r = head.n;
    end else begin
      win_l = head.has_a ? head.c : '0;
      win_c = head.n;
      win_r = '0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (issue) begin
      phase_d = !pop;
    end
  end

  always_comb begin
    // Cardinal: S, W, E, N.
    s1_card_d[0] = drop_of(win_c.present && win_c.below_ok, win_c.v[2], win_c.v[1]);
    s1_card_d[1] = drop_of(win_l.present, win_l.v[1], win_c.v[1]);
    s1_card_d[2] = drop_of(win_r.present, win_r.v[1], win_c.v[1]);
    s1_card_d[3] = drop_of(win_c.present && win_c.above_ok, win_c.v[0], win_c.v[1]);
    // Diagonal: SW, SE, NW, NE.
    s1_diag_d[0] = drop_of(win_l.present && win_l.below_ok, win_l.v[2], win_c.v[1]);
    s1_diag_d[1] = drop_of(win_r.present && win_r.below_ok, win_r.v[2], win_c.v[1]);
    s1_diag_d[2] = drop_of(win_l.present && win_l.above_ok, win_l.v[0], win_c.v[1]);
    s1_diag_d[3] = drop_of(win_r.present && win_r.above_ok, win_r.v[0], win_c.v[1]);
  end

  // Pairwise tree; the later entry wins only on a strictly larger drop.
  always_comb begin
    logic [ElevBits-1:0] ca, cb, da, db;
    logic [3:0]          cca, ccb, cda, cdb;
    ca  = (s1_card_q[1] > s1_card_q[0]) ? s1_card_q[1] : s1_card_q[0];
    cca = (s1_card_q[1] > s1_card_q[0]) ? DIR_W : DIR_S;
    cb  = (s1_card_q[3] > s1_card_q[2]) ? s1_card_q[3] : s1_card_q[2];
    ccb = (s1_card_q[3] > s1_card_q[2]) ? DIR_N : DIR_E;
    da  = (s1_diag_q[1] > s1_diag_q[0]) ? s1_diag_q[1] : s1_diag_q[0];
    cda = (s1_diag_q[1] > s1_diag_q[0]) ? DIR_SE : DIR_SW;
    db  = (s1_diag_q[3] > s1_diag_q[2]) ? s1_diag_q[3] : s1_diag_q[2];
    cdb = (s1_diag_q[3] > s1_diag_q[2]) ? DIR_NE : DIR_NW;
    s2_dc_d = (cb > ca) ? cb : ca;
    s2_cc_d = (cb > ca) ? ccb : cca;
    s2_dd_d = (db > da) ? db : da;
    s2_cd_d = (db > da) ? cdb : cda;
    if (s2_dc_d == '0) begin
      s2_cc_d = DIR_NONE;
    end
    if (s2_dd_d == '0) begin
      s2_cd_d = DIR_NONE;
    end
  end

  always_comb begin
    if (s3_wc_q > s3_wd_q) begin
      out_d.direction = s3_cc_q;
    end else if (s3_wd_q > s3_wc_q) begin
      out_d.direction = s3_cd_q;
    end else begin
      // Equal weights: the lower code wins; both are none when nothing is lower.
      out_d.direction = (s3_cc_q < s3_cd_q) ? s3_cc_q : s3_cd_q;
    end
    out_d.last_of_run = s3_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (adv) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q <= win_last;
      s1_card_q <= s1_card_d;
      s1_diag_q <= s1_diag_d;
      s2_last_q <= s1_last_q;
      s2_dc_q   <= s2_dc_d;
      s2_dd_q   <= s2_dd_d;
      s2_cc_q   <= s2_cc_d;
      s2_cd_q   <= s2_cd_d;
      s3_last_q <= s2_last_q;
      s3_wc_q   <= WeightW'(s2_dc_q) * WeightW'(SQRT2_Q16);
      s3_wd_q   <= WeightW'({s2_dd_q, {Q_FRAC{1'b0}}});
      s3_cc_q   <= s2_cc_q;
      s3_cd_q   <= s2_cd_q;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/d8_steepest_descent_direction_top.sv */
// ----------------------------------------------------------------------------
// D8 flow direction top level
// Streams column slices of an elevation raster and gives each pixel the
// keypad chain code of its steepest downhill neighbour.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (d8sdd_in_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (d8sdd_out_t)
//
// One slice can be taken every cycle while the job queue has room; a slice
// yields zero, one or two results and the output delivers one result per
// cycle while out_ready_i is high, so a row end with a held center adds a
// second result on the output side. A slice passes the queue and the drops,
// group maxima, slope weighting and output registers before its first result.
// Reset empties both column slots, the job queue and the evaluation pipeline.
// Output back-pressure freezes the evaluation pipeline; the two-entry job queue
// then fills and in_ready_o falls.
// ----------------------------------------------------------------------------
`default_nettype none

module d8_steepest_descent_direction_top #(
  parameter int unsigned ELEV_BITS = d8sdd_pkg::ELEV_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire d8sdd_pkg::d8sdd_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output d8sdd_pkg::d8sdd_out_t      out_data_o
);
  import d8sdd_pkg::*;

  localparam int unsigned JobW = job_w(ELEV_BITS);

  logic            push_valid, push_ready;
  logic [JobW-1:0] push_job;
  logic            job_valid, job_ready;
  logic [JobW-1:0] job;
  d8sdd_front_st_t front_st;

  d8sdd_front #(
    .ElevBits (ELEV_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job),
    .status_o     (front_st)
  );

  d8sdd_queue #(
    .Width (JobW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job)
  );

  d8sdd_back #(
    .ElevBits (ELEV_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A left column is only ever held behind a center column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.have_left |-> front_st.have_center)
    else $error("left column held without a center column");

  // A row end empties the column slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.row_end) |=>
      (!front_st.have_center && !front_st.have_left))
    else $error("column slots not emptied after a row end");

  // The centre code is never a direction, and nothing above the north-east code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.direction != DIR_CENTRE) &&
                     (out_data_o.direction <= DIR_NE)))
    else $error("direction code out of range");

  // The first slice of a row with no row end gives no job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !front_st.have_center && !in_data_i.row_end) |-> !push_valid)
    else $error("job pushed for the first slice of a row");

endmodule

`default_nettype wire
